// ----- hdl/sigmoid_cross_entropy_row_loss_top_assert.svh -----
// ----------------------------------------------------------------------------
// sigmoid cross-entropy row loss: assertion macros
// concurrent checks clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef SIGMOID_CROSS_ENTROPY_ROW_LOSS_TOP_ASSERT_SVH
`define SIGMOID_CROSS_ENTROPY_ROW_LOSS_TOP_ASSERT_SVH

// same-cycle implication
`define SCE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/sce_pkg.sv -----
// ----------------------------------------------------------------------------
// sce_pkg
// shared widths, queue entry and divider request types and the softplus log table
// ----------------------------------------------------------------------------
`default_nettype none

package sce_pkg;

  localparam int LOGIT_W        = 16;
  localparam int TARGET_W       = 16;
  localparam int LOSS_W         = 24;
  localparam int LEN_W          = 13;
  localparam int CNT_W          = 12;
  localparam int SUM_W          = 40;
  localparam int NUM_W          = SUM_W + 1;
  localparam int DIV_CNT_W      = $clog2(NUM_W + 1);
  localparam int MAX_ROW_LENGTH = 4096;
  localparam int SP_ENTRIES     = 256;
  localparam int LOG_DOMAIN     = 4096;
  localparam int LOG_DOMAIN_W   = $clog2(LOG_DOMAIN);
  localparam int SP_IDX_W       = $clog2(SP_ENTRIES);
  localparam int SP_SHIFT       = $clog2(LOG_DOMAIN / SP_ENTRIES);
  localparam int SP_W           = 16;
  localparam int MAG_W          = LOGIT_W + 1;
  localparam int WGT_W          = TARGET_W;
  localparam int PROD_W         = 31;
  localparam int LIN_W          = PROD_W - 7;
  localparam int ELEM_W         = LIN_W + 1;
  localparam int Q_DEPTH        = 4;
  localparam int Q_PTR_W        = $clog2(Q_DEPTH);
  localparam logic [TARGET_W-1:0] T_ONE = 16'h8000;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [WGT_W-1:0] wgt;
    logic [SP_W-1:0]  sp;
  } elem_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] numer;
  } div_req_t;

  typedef logic [SP_W-1:0] sp_table_t [SP_ENTRIES];

  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], a[i]};
      if (rem >= b) begin
        rem  = rem - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] exp_neg_q30(input logic [63:0] r);
    logic signed [63:0] acc;
    logic [63:0]        term;
    logic [63:0]        v;
    acc  = 64'sd1 <<< 30;
    term = 64'd1 << 30;
    for (int n = 1; n <= 12; n++) begin
      term = udiv64((term * r) >> 30, 64'(n));
      if (n % 2 == 1) acc = acc - $signed(term);
      else            acc = acc + $signed(term);
    end
    v = (acc > 0) ? 64'(acc) : 64'd0;
    for (int s = 0; s < 5; s++) v = (v * v + (64'd1 << 29)) >> 30;
    return v;
  endfunction

  function automatic logic [63:0] log1p_q30(input logic [63:0] y);
    logic [63:0] z;
    logic [63:0] zz;
    logic [63:0] pw;
    logic [63:0] acc;
    z   = udiv64(y << 30, (64'd1 << 31) + y);
    zz  = (z * z) >> 30;
    pw  = z;
    acc = '0;
    for (int n = 0; n < 16; n++) begin
      acc = acc + udiv64(pw, 64'(2 * n + 1));
      pw  = (pw * zz) >> 30;
    end
    return acc * 2;
  endfunction

  function automatic sp_table_t build_sp_table();
    sp_table_t   tbl;
    logic [63:0] den;
    logic [63:0] r;
    logic [63:0] lg;
    den = 64'(4 * SP_ENTRIES);
    for (int k = 0; k < SP_ENTRIES; k++) begin
      r      = udiv64((64'(2 * k + 1) << 30) + (den >> 1), den);
      lg     = log1p_q30(exp_neg_q30(r));
      tbl[k] = SP_W'((lg + (64'd1 << 13)) >> 14);
    end
    return tbl;
  endfunction

  localparam sp_table_t SP_TABLE = build_sp_table();

endpackage

`default_nettype wire

// ----- hdl/sigmoid_cross_entropy_row_loss_top.sv -----
// ----------------------------------------------------------------------------
// sigmoid_cross_entropy_row_loss_top
// mean sigmoid cross-entropy over rows of (logit, target) items
// ----------------------------------------------------------------------------
//  channel | signals                       | dir
//  in      | in_valid in_ready logit target | in
//  out     | out_valid out_ready row_loss   | out
//  cfg     | cfg_wr_en cfg_wr_data          | in
//
//  one item per cycle within a row, front queue of four items
//  the last item of a row starts the divider
//  the next row end waits while the divider runs or its result is held
//  other items keep flowing; the front fills the queue meanwhile
//  synchronous reset; row_length resets to 1
// ----------------------------------------------------------------------------
`default_nettype none

module sigmoid_cross_entropy_row_loss_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [sce_pkg::LOGIT_W-1:0]  logit,
  input  wire logic [sce_pkg::TARGET_W-1:0] target,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [sce_pkg::LOSS_W-1:0]        row_loss,
  input  wire logic                         cfg_wr_en,
  input  wire logic [sce_pkg::LEN_W-1:0]    cfg_wr_data
);
  import sce_pkg::*;

  logic [LEN_W-1:0] row_length;
  logic [LEN_W-1:0] len;
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  elem_t            push_data;
  elem_t            pop_data;
  div_req_t         div_req;
  logic             div_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= LEN_W'(1);
    end else if (cfg_wr_en) begin
      row_length <= cfg_wr_data;
    end
  end

  always_comb begin
    if (row_length == '0) begin
      len = LEN_W'(1);
    end else if (row_length > LEN_W'(MAX_ROW_LENGTH)) begin
      len = LEN_W'(MAX_ROW_LENGTH);
    end else begin
      len = row_length;
    end
  end

  sce_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .logit    (logit),
    .target   (target),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (push_data)
  );

  sce_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  sce_back u_back (
    .clk      (clk),
    .rst      (rst),
    .len      (len),
    .q_empty  (q_empty),
    .q_data   (pop_data),
    .q_pop    (q_pop),
    .div_busy (div_busy),
    .div_req  (div_req)
  );

  sce_div u_div (
    .clk       (clk),
    .rst       (rst),
    .req       (div_req),
    .len       (len),
    .busy      (div_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .row_loss  (row_loss)
  );

`include "sigmoid_cross_entropy_row_loss_top_assert.svh"

  `SCE_ASSERT_NOW(a_no_push_full, q_push, !q_full, "push into full queue")
  `SCE_ASSERT_NOW(a_no_pop_empty, q_pop, !q_empty, "pop from empty queue")
  `SCE_ASSERT_NOW(a_div_idle_start, div_req.start, !div_busy, "divider restarted while busy")
  `SCE_ASSERT_NEXT(a_div_takes, div_req.start, div_busy && !out_valid, "divider did not start")

endmodule

`default_nettype wire

// ----- hdl/sce_front.sv -----
// ----------------------------------------------------------------------------
// sce_front
// takes items, forms |x|, the linear weight and the softplus table term
// ----------------------------------------------------------------------------
`default_nettype none

module sce_front (
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [sce_pkg::LOGIT_W-1:0]    logit,
  input  wire logic [sce_pkg::TARGET_W-1:0]   target,
  input  wire logic                           q_full,
  output logic                                q_push,
  output sce_pkg::elem_t                      q_data
);
  import sce_pkg::*;

  logic                nonneg;
  logic [MAG_W-1:0]    mag;
  logic [TARGET_W-1:0] t_sat;

  always_comb begin
    nonneg = ~logit[LOGIT_W-1];
    mag    = nonneg ? {1'b0, logit} : (MAG_W'(1) << LOGIT_W) - {1'b0, logit};
    t_sat  = (target > T_ONE) ? T_ONE : target;
    q_data.mag = mag;
    q_data.wgt = nonneg ? (T_ONE - t_sat) : t_sat;
    if (mag < MAG_W'(LOG_DOMAIN)) begin
      q_data.sp = SP_TABLE[mag[LOG_DOMAIN_W-1:SP_SHIFT]];
    end else begin
      q_data.sp = '0;
    end
  end

  assign in_ready = ~q_full;
  assign q_push   = in_valid & ~q_full;

endmodule

`default_nettype wire

// ----- hdl/sce_queue.sv -----
// ----------------------------------------------------------------------------
// sce_queue
// small fifo between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module sce_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire sce_pkg::elem_t push_data,
  output logic                full,
  input  wire logic           pop,
  output sce_pkg::elem_t      pop_data,
  output logic                empty
);
  import sce_pkg::*;

  elem_t              mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign pop_data = mem[rd_ptr];
  assign full     = (count == (Q_PTR_W + 1)'(Q_DEPTH));
  assign empty    = (count == '0);

endmodule

`default_nettype wire

// ----- hdl/sce_back.sv -----
// ----------------------------------------------------------------------------
// sce_back
// multiplies, accumulates the row and hands the row sum to the divider
// ----------------------------------------------------------------------------
`default_nettype none

module sce_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [sce_pkg::LEN_W-1:0] len,
  input  wire logic                      q_empty,
  input  wire sce_pkg::elem_t            q_data,
  output logic                           q_pop,
  input  wire logic                      div_busy,
  output sce_pkg::div_req_t              div_req
);
  import sce_pkg::*;

  logic              mult_valid;
  logic [PROD_W-1:0] prod;
  logic [SP_W-1:0]   sp;
  logic [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]  count;

  logic [PROD_W:0]   rounded;
  logic [ELEM_W-1:0] elem;
  logic [SUM_W:0]    sum_wide;
  logic [SUM_W-1:0]  sum_next;
  logic              is_last;
  logic              acc_fire;
  logic [2*MAG_W-1:0] full_prod;

  always_comb begin
    rounded   = {1'b0, prod} + (PROD_W + 1)'(64);
    elem      = rounded[PROD_W:7] + ELEM_W'(sp);
    sum_wide  = {1'b0, sum} + (SUM_W + 1)'(elem);
    sum_next  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    is_last   = ({1'b0, count} + LEN_W'(1)) >= len;
    acc_fire  = mult_valid && (!is_last || !div_busy);
    q_pop     = !q_empty && (!mult_valid || acc_fire);
    full_prod = q_data.mag * {1'b0, q_data.wgt};
    div_req.start = acc_fire && is_last;
    div_req.numer = {1'b0, sum_next} + NUM_W'(len >> 1);
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      prod <= full_prod[PROD_W-1:0];
      sp   <= q_data.sp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mult_valid <= 1'b0;
      sum        <= '0;
      count      <= '0;
    end else begin
      if (q_pop) begin
        mult_valid <= 1'b1;
      end else if (acc_fire) begin
        mult_valid <= 1'b0;
      end
      if (acc_fire) begin
        if (is_last) begin
          sum   <= '0;
          count <= '0;
        end else begin
          sum   <= sum_next;
          count <= count + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sce_div.sv -----
// ----------------------------------------------------------------------------
// sce_div
// restoring divider, one quotient bit per cycle, and the output register
// ----------------------------------------------------------------------------
`default_nettype none

module sce_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire sce_pkg::div_req_t          req,
  input  wire logic [sce_pkg::LEN_W-1:0]  len,
  output logic                            busy,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [sce_pkg::LOSS_W-1:0]      row_loss
);
  import sce_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]           state;
  logic [DIV_CNT_W-1:0] steps;
  logic [NUM_W-1:0]     num;
  logic [LEN_W:0]       rem;
  logic [LEN_W-1:0]     den;
  logic [LEN_W:0]       rem_sh;
  logic [LEN_W:0]       diff;

  always_comb begin
    rem_sh = {rem[LEN_W-1:0], num[NUM_W-1]};
    diff   = rem_sh - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num <= req.numer;
      den <= len;
      rem <= '0;
    end else if (state == ST_RUN) begin
      num <= {num[NUM_W-2:0], ~diff[LEN_W]};
      rem <= diff[LEN_W] ? rem_sh : diff;
    end
    if (state == ST_RUN && steps == DIV_CNT_W'(1)) begin
      row_loss <= (|num[NUM_W-2:LOSS_W-1]) ? {LOSS_W{1'b1}}
                                           : {num[LOSS_W-2:0], ~diff[LEN_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      steps <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req.start) begin
            state <= ST_RUN;
            steps <= DIV_CNT_W'(NUM_W);
          end
        end
        ST_RUN: begin
          steps <= steps - 1'b1;
          if (steps == DIV_CNT_W'(1)) state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign busy      = (state != ST_IDLE);
  assign out_valid = (state == ST_DONE);

endmodule

`default_nettype wire
